### rtl/core/lrr_pkg.sv
// shared constants and types of the longest run with replacements block
package lrr_pkg;

  localparam int unsigned MaxLenDef   = 1024;
  localparam int unsigned AlphabetDef = 26;
  localparam int unsigned LetterW     = 5;
  localparam int unsigned CfgW        = 11;
  localparam int unsigned OutW        = 11;

  // update command for the letter count cells
  typedef struct packed {
    logic               clr;
    logic               inc;
    logic               dec;
    logic [LetterW-1:0] sym;
    logic [LetterW-1:0] old;
  } cnt_ctrl_t;

  // one result beat, best length in the low bits
  typedef struct packed {
    logic            overflow;
    logic [OutW-1:0] window_length;
    logic [OutW-1:0] best_length;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

endpackage

### rtl/core/longest_run_with_replacements.sv
// top level: longest letter run with replacements over a sliding window
//
// input beats carry one letter index (tdata) and a start-of-string flag
// (tuser); a start flag clears all string state before its letter counts.
// every input beat yields exactly one output beat with the best window
// length, the current window length and the overflow flag.
// the step itself runs in the accept cycle against the count cells and the
// oldest window symbol, which the history ring reads ahead into a register;
// a new beat is taken every cycle unless the output buffer is full, so
// throughput is one letter per clock while the receiver keeps up.
// the ring read port is the only sequential path in the step: its address
// always follows the next window start, with forwarding when that entry
// is written in the same cycle. results go into a two-entry output buffer:
// a stalled receiver still lets one more beat in, then s_axis_tready drops
// until the buffer drains. reset clears counts, window, best length,
// overflow and max_replacements; no clearing pass over the ring is needed.
// max_replacements is written by the user through cfg_wr_en_i/cfg_wr_data_i
// only while the block is idle; the block itself does not enforce this.
module longest_run_with_replacements import lrr_pkg::*; #(
  parameter int unsigned MAX_LEN  = MaxLenDef,
  parameter int unsigned ALPHABET = AlphabetDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port (max_replacements)
  input  logic        cfg_wr_en_i,
  input  logic [10:0] cfg_wr_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  logic        s_axis_tuser,   // [0] first
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [10:0] best_length, [21:11] window_length,
                                      // [22] overflow, [23] zero
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned DW = ((CW > CfgW) ? CW : CfgW) + 1;

  // architectural string state
  logic [CW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   ws_q, ws_d;
  logic [CW-1:0]   largest_q, largest_d;
  logic [CW-1:0]   best_q, best_d;
  logic            ovf_q, ovf_d;
  logic [CfgW-1:0] max_repl_q;

  // step signals
  logic               acc;
  logic               first;
  logic [LetterW-1:0] sym;
  logic [CW-1:0]      pos_eff, ws_eff, largest_eff, best_eff;
  logic               ovf_eff;
  logic               take, room, add;
  logic [CW-1:0]      sym_cnt, sym_cnt_new, largest_new;
  logic [CW-1:0]      len_full, len_fin;
  logic               drop;
  logic [LetterW-1:0] old_sym;
  logic [AW-1:0]      rd_addr;
  cnt_ctrl_t          cnt_ctrl;
  res_t               res;
  logic               obuf_ready;
  logic [ResW-1:0]    obuf_data;

  assign s_axis_tready = obuf_ready;
  assign acc   = s_axis_tvalid && obuf_ready;
  assign first = s_axis_tuser;
  assign sym   = s_axis_tdata[LetterW-1:0];

  // start flag clears the string before this letter
  assign pos_eff     = first ? '0 : pos_q;
  assign ws_eff      = first ? '0 : ws_q;
  assign largest_eff = first ? '0 : largest_q;
  assign best_eff    = first ? '0 : best_q;
  assign ovf_eff     = first ? 1'b0 : ovf_q;

  // out-of-range letters and letters after overflow leave state alone
  assign take = acc && (32'(sym) < ALPHABET) && !ovf_eff;
  assign room = (32'(pos_eff) < MAX_LEN);
  assign add  = take && room;

  assign sym_cnt_new = sym_cnt + CW'(1);
  assign largest_new = (sym_cnt_new > largest_eff) ? sym_cnt_new : largest_eff;
  assign len_full    = pos_eff + CW'(1) - ws_eff;

  // window may not hold more replaced letters than allowed: slide by one
  assign drop = add &&
                (DW'(len_full) > (DW'(largest_new) + DW'(max_repl_q)));
  assign len_fin = len_full - CW'(drop);

  always_comb begin
    pos_d     = pos_q;
    ws_d      = ws_q;
    largest_d = largest_q;
    best_d    = best_q;
    ovf_d     = ovf_q;
    if (acc) begin
      pos_d     = pos_eff + CW'(add);
      ws_d      = ws_eff + CW'(drop);
      largest_d = add ? largest_new : largest_eff;
      best_d    = (add && (len_fin > best_eff)) ? len_fin : best_eff;
      ovf_d     = ovf_eff || (take && !room);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      ws_q       <= '0;
      largest_q  <= '0;
      best_q     <= '0;
      ovf_q      <= 1'b0;
      max_repl_q <= '0;
    end else begin
      pos_q     <= pos_d;
      ws_q      <= ws_d;
      largest_q <= largest_d;
      best_q    <= best_d;
      ovf_q     <= ovf_d;
      if (cfg_wr_en_i) begin
        max_repl_q <= cfg_wr_data_i;
      end
    end
  end

  // per-letter counts: add the new letter, retire the oldest on a slide
  assign cnt_ctrl.clr = acc && first;
  assign cnt_ctrl.inc = add;
  assign cnt_ctrl.dec = drop && (32'(old_sym) < ALPHABET);
  assign cnt_ctrl.sym = sym;
  assign cnt_ctrl.old = old_sym;

  lrr_counts #(
    .ALPHABET (ALPHABET),
    .CW       (CW)
  ) u_counts (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cnt_ctrl),
    .sym_cnt_o (sym_cnt)
  );

  // prefetch the symbol at the next window start
  assign rd_addr = (32'(ws_d) < MAX_LEN) ? ws_d[AW-1:0] : '0;

  lrr_ring #(
    .MAX_LEN (MAX_LEN)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (add),
    .wr_addr_i (pos_eff[AW-1:0]),
    .wr_data_i (sym),
    .rd_addr_i (rd_addr),
    .rd_data_o (old_sym)
  );

  // result beat after this letter
  assign res.best_length   = OutW'(best_d);
  assign res.window_length = OutW'(pos_d - ws_d);
  assign res.overflow      = ovf_d;

  lrr_obuf #(
    .W (ResW)
  ) u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (acc),
    .data_i      (res),
    .ready_o     (obuf_ready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (obuf_data)
  );

  assign m_axis_tdata = {1'b0, obuf_data};

endmodule

### rtl/core/lrr_ring.sv
// history ring memory with read-during-write forwarding
module lrr_ring import lrr_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDef,
  localparam int unsigned AW     = $clog2(MAX_LEN)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [LetterW-1:0] wr_data_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [LetterW-1:0] rd_data_o
);

  logic [LetterW-1:0] mem [MAX_LEN];
  logic [LetterW-1:0] rd_q;
  logic [LetterW-1:0] fwd_data_q;
  logic               fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q       <= mem[rd_addr_i];
    fwd_data_q <= wr_data_i;
  end

  // same entry written and read in one cycle: take the new symbol
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

### rtl/core/lrr_counts.sv
// row of per-letter count cells with increment, decrement and clear
module lrr_counts import lrr_pkg::*; #(
  parameter int unsigned ALPHABET = AlphabetDef,
  parameter int unsigned CW       = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cnt_ctrl_t       ctrl_i,
  output logic [CW-1:0]   sym_cnt_o
);

  logic [CW-1:0] cnt_q [ALPHABET];
  logic [CW-1:0] sel;

  // count of the incoming letter as seen after an optional clear
  always_comb begin
    sel = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      if (32'(ctrl_i.sym) == i) begin
        sel = cnt_q[i];
      end
    end
    sym_cnt_o = ctrl_i.clr ? '0 : sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ALPHABET; i++) begin
        cnt_q[i] <= (ctrl_i.clr ? '0 : cnt_q[i])
                  + CW'(ctrl_i.inc && (32'(ctrl_i.sym) == i))
                  - CW'(ctrl_i.dec && (32'(ctrl_i.old) == i));
      end
    end
  end

endmodule

### rtl/core/lrr_obuf.sv
// two-entry output register with skid slot
module lrr_obuf import lrr_pkg::*; #(
  parameter int unsigned W = ResW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] data_o
);

  logic         out_valid_q;
  logic         skid_valid_q;
  logic [W-1:0] out_q;
  logic [W-1:0] skid_q;
  logic         slot_free;

  assign slot_free = !out_valid_q || pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

### test/testbench.sv
// testbench for the longest run with replacements block: predicted results vs. output beats
module testbench;
  import lrr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 3000;  // cycles with no beat on either side

  // window predictor plus the queue of results it has worked out
  class run_scoreboard;
    int unsigned       letter_counts[AlphabetDef];
    logic [LetterW-1:0] letter_ring[MaxLenDef];
    int unsigned       win_start;
    int unsigned       letters_held;
    int unsigned       top_count;
    int unsigned       best_len;
    bit                overflowed;
    int unsigned       max_repl;
    res_t              expected_results[$];
    int                errors;
    int                checked;

    function new();
      max_repl = 0;
      errors   = 0;
      checked  = 0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (letter_counts[i]) letter_counts[i] = 0;
      win_start    = 0;
      letters_held = 0;
      top_count    = 0;
      best_len     = 0;
      overflowed   = 1'b0;
    endfunction

    function void set_replacements(logic [CfgW-1:0] value);
      max_repl = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // one accepted letter: advance the window and queue the result it causes
    function void note_letter(logic [LetterW-1:0] sym, logic first);
      int unsigned        win_len;
      logic [LetterW-1:0] oldest;
      res_t               want;
      if (first) clear_string();
      if (sym < AlphabetDef && !overflowed) begin
        if (letters_held >= MaxLenDef) begin
          overflowed = 1'b1;
        end else begin
          letter_ring[letters_held] = sym;
          letters_held++;
          letter_counts[sym]++;
          if (letter_counts[sym] > top_count) top_count = letter_counts[sym];
          win_len = letters_held - win_start;
          // too many letters to replace: the oldest one leaves, window keeps its size
          if (win_len - top_count > max_repl) begin
            oldest = letter_ring[win_start % MaxLenDef];
            if (oldest < AlphabetDef && letter_counts[oldest] > 0) letter_counts[oldest]--;
            win_start++;
            win_len--;
          end
          if (win_len > best_len) best_len = win_len;
        end
      end
      want.best_length   = OutW'(best_len);
      want.window_length = OutW'(letters_held - win_start);
      want.overflow      = overflowed;
      expected_results.push_back(want);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.best_length !== want.best_length) begin
        errors++;
        $display("%0t: best_length expected %0d actual %0d", $time,
                 want.best_length, got.best_length);
      end
      if (got.window_length !== want.window_length) begin
        errors++;
        $display("%0t: window_length expected %0d actual %0d", $time,
                 want.window_length, got.window_length);
      end
      if (got.overflow !== want.overflow) begin
        errors++;
        $display("%0t: overflow expected %0b actual %0b", $time,
                 want.overflow, got.overflow);
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_wr_en_i   = 1'b0;
  logic [10:0] cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [4:0] letter, [7:5] zero
  logic        s_axis_tuser  = 1'b0;  // [0] first
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // [10:0] best_length, [21:11] window_length, [22] overflow

  run_scoreboard sb;

  // sender burst shaping
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  always #10 clk_i = ~clk_i;

  longest_run_with_replacements u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // offer one letter beat and return at the edge that accepts it
  task automatic send_letter(input logic [LetterW-1:0] sym, input logic first);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, sym};
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_letter(sym, first);
  endtask

  // drop valid and wait until every queued result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write only while nothing is in flight
  task automatic write_replacements(input logic [CfgW-1:0] value);
    drain();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    sb.set_replacements(value);
  endtask

  // mostly a dominant letter so runs form, a few neighbors, rare invalid codes
  function automatic logic [LetterW-1:0] pick_letter(int base, int spread);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return LetterW'($urandom_range(AlphabetDef, 31));
    if (roll < 55) return LetterW'(base);
    return LetterW'((base + $urandom_range(0, spread - 1)) % AlphabetDef);
  endfunction

  // one string; without the start flag it just extends the current one
  task automatic send_string(input int len, input int spread, input bit with_first);
    int base;
    base = $urandom_range(0, AlphabetDef - 1);
    for (int i = 0; i < len; i++) begin
      send_letter(pick_letter(base, spread), with_first && i == 0);
    end
  endtask

  task automatic run_phase(input logic [CfgW-1:0] value, input int budget);
    int sent;
    int len;
    write_replacements(value);
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 12) : $urandom_range(13, 60);
      send_string(len, $urandom_range(1, 5), $urandom_range(0, 9) != 0);
      sent += len;
    end
  endtask

  // stimulus and the end of the run
  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state is an empty string: letters extend it without a start flag
    send_letter(5'd0, 1'b0);
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    // invalid letter with start flag still clears, then an ignored invalid letter
    send_letter(5'd31, 1'b1);
    send_letter(5'd26, 1'b0);
    // no replacements allowed: window slides on every foreign valid letter
    send_letter(5'd3, 1'b1);
    send_letter(5'd3, 1'b0);
    send_letter(5'd4, 1'b0);
    send_letter(5'd3, 1'b0);
    send_letter(5'd30, 1'b0);
    send_letter(5'd25, 1'b0);

    write_replacements(11'd1);
    send_letter(5'd1, 1'b1);
    send_letter(5'd2, 1'b0);
    send_letter(5'd1, 1'b0);
    send_letter(5'd2, 1'b0);
    send_letter(5'd2, 1'b0);
    send_letter(5'd7, 1'b0);
    send_letter(5'd1, 1'b1);
    send_letter(5'd1, 1'b0);

    // replacements at 1024: one string of 1040 letter beats, longer than the length limit
    write_replacements(11'd1024);
    gaps_on = 1'b1;
    send_string(1040, 3, 1'b1);
    for (int i = 0; i < 6; i++) send_letter(LetterW'($urandom_range(0, 31)), 1'b0);
    run_phase(11'd1024, 60);

    gaps_on = 1'b0;
    run_phase(11'd2047, 70);
    gaps_on = 1'b1;
    run_phase(11'd0, 70);
    gaps_on = 1'b0;
    run_phase(11'd1023, 70);
    gaps_on = 1'b1;
    run_phase(11'd1, 70);
    run_phase(11'd3, 70);
    gaps_on = 1'b0;
    run_phase(CfgW'($urandom_range(2, 12)), 70);

    // all letters in: wait for the last results, then a few quiet cycles
    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver: its own stall pattern, plus one long hold-off that backs up the input
  initial begin
    int  cyc;
    bit  held;
    cyc  = 0;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && sb.checked >= 500) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        case ((cyc / 97) % 3)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 2) != 0);
          default: m_axis_tready <= ((cyc % 5) < 2);
        endcase
        @(posedge clk_i);
        cyc++;
      end
    end
  end

  // result beats go to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(res_t'(m_axis_tdata[ResW-1:0]));
    end
  end

  // watchdog: too long with no beat on either side ends the run
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t: no beat for %0d cycles", $time, IdleLimit);
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
